// ===== hw/rtl/cbf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types and constants for the counting Bloom filter core: field widths,
// operation codes and the update status passed between the datapath modules.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // fixed payload widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CNT_W   = 13;

  typedef logic [KIND_W-1:0] kind_t;

  // operation codes; the unused code behaves as a query
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_QUERY  = 2'd2;

  // status of one counter update
  typedef struct packed {
    logic wr;       // counter is written back
    logic inc;      // counter went from zero to nonzero
    logic dec;      // counter went from nonzero to zero
    logic nonzero;  // resulting value is nonzero
  } cbf_upd_t;

endpackage : cbf_pkg
`default_nettype wire

// ===== hw/rtl/cbf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_if
// Valid/ready channel interfaces: request items in, result items out.
// ----------------------------------------------------------------------------
interface cbf_in_if
  import cbf_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0] index;
  logic             last;

  modport source (output valid, output kind, output index, output last, input ready);
  modport sink   (input valid, input kind, input index, input last, output ready);
endinterface : cbf_in_if

interface cbf_out_if
  import cbf_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] slot;
  logic [VAL_W-1:0] value;
  logic             all_present;
  logic             group_end;
  logic [CNT_W-1:0] nonzero_count;

  modport source (output valid, output slot, output value, output all_present,
                  output group_end, output nonzero_count, input ready);
  modport sink   (input valid, input slot, input value, input all_present,
                  input group_end, input nonzero_count, output ready);
endinterface : cbf_out_if
`default_nettype wire

// ===== hw/rtl/cbf_counter_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_counter_mem
// Counter RAM, one read and one write port, registered read data. The last
// write is mirrored so a read that raced a write to the same entry returns
// the fresh value.
// ----------------------------------------------------------------------------
module cbf_counter_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned CW    = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [CW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [CW-1:0] wr_data
);

  logic [CW-1:0] ram [DEPTH];
  logic [CW-1:0] ram_q_r;
  logic [AW-1:0] rd_addr_r;
  logic [AW-1:0] wr_addr_r;
  logic [CW-1:0] wr_data_r;
  logic          wr_vld_r;

  // memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q_r   <= ram[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // mirror of the most recent write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else if (wr_en) begin
      wr_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_addr_r <= wr_addr;
      wr_data_r <= wr_data;
    end
  end

  // forward the mirrored write when it hit the entry just read
  assign rd_data = (wr_vld_r && (wr_addr_r == rd_addr_r)) ? wr_data_r : ram_q_r;

endmodule : cbf_counter_mem
`default_nettype wire

// ===== hw/rtl/cbf_clear.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_clear
// Post-reset sweep that zeroes the counter RAM, one entry per cycle.
// ----------------------------------------------------------------------------
module cbf_clear #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  output logic               clearing,
  output logic      [AW-1:0] clr_addr
);

  logic          clearing_r;
  logic [AW-1:0] addr_r;

  // sweep address and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      addr_r     <= '0;
    end else if (clearing_r) begin
      addr_r <= addr_r + AW'(1);
      if (addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign clearing = clearing_r;
  assign clr_addr = addr_r;

endmodule : cbf_clear
`default_nettype wire

// ===== hw/rtl/cbf_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_update
// Counter modify step: saturating increment, floored decrement or plain
// read, with the occupancy change that results.
// ----------------------------------------------------------------------------
module cbf_update
  import cbf_pkg::*;
#(
  parameter int unsigned CW = 16
) (
  input  wire kind_t         kind,
  input  wire logic          in_range,
  input  wire logic [CW-1:0] old_val,
  output logic      [CW-1:0] new_val,
  output cbf_upd_t           upd
);

  logic [CW-1:0] mod_val;

  // apply the operation
  always_comb begin
    mod_val = old_val;
    case (kind)
      KIND_INSERT: begin
        if (old_val != {CW{1'b1}}) begin
          mod_val = old_val + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (old_val != '0) begin
          mod_val = old_val - CW'(1);
        end
      end
      default: begin
        mod_val = old_val;
      end
    endcase
  end

  // out-of-table index touches nothing and reads as zero
  always_comb begin
    new_val     = in_range ? mod_val : '0;
    upd.wr      = in_range;
    upd.inc     = in_range && (old_val == '0) && (mod_val != '0);
    upd.dec     = in_range && (old_val != '0) && (mod_val == '0);
    upd.nonzero = in_range && (mod_val != '0);
  end

endmodule : cbf_update
`default_nettype wire

// ===== hw/rtl/counting_bloom_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// counting_bloom_filter_core
// Counting Bloom filter table: per-item counter update with group membership
// flag and a running count of nonzero counters.
// ----------------------------------------------------------------------------
// Pipeline: RAM read register, then the modify step into the output register.
// Throughput: 1 item per cycle when out_ch is not stalled, set by the single counter
//   RAM read/write port pair; back-to-back hits on one entry use write forwarding.
// Reset: synchronous, active low; the counter RAM is then zeroed by a sweep of
//   min(TABLE_SIZE, 4096) entries (4096 by default); in_ch.ready is low meanwhile.
// ----------------------------------------------------------------------------
module counting_bloom_filter_core
  import cbf_pkg::*;
#(
  parameter int unsigned TABLE_SIZE   = 4096,
  parameter int unsigned COUNTER_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cbf_in_if.sink    in_ch,
  cbf_out_if.source out_ch
);

  localparam int unsigned MEM_DEPTH = (TABLE_SIZE < (1 << IDX_W)) ? TABLE_SIZE : (1 << IDX_W);
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned CW        = COUNTER_BITS;

  // handshake
  logic in_fire;
  logic s1_fire;
  logic clearing;
  logic [AW-1:0] clr_addr;

  // stage 1: RAM data available
  logic             s1_vld_r;
  kind_t            s1_kind_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_last_r;
  logic             s1_in_range;

  // running state
  logic [CNT_W-1:0] occ_r;
  logic [CNT_W-1:0] occ_nxt;
  logic             grp_r;
  logic             grp_nxt;
  logic             all_now;

  // output register
  logic             out_vld_r;
  logic [IDX_W-1:0] out_slot_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_all_r;
  logic             out_end_r;
  logic [CNT_W-1:0] out_cnt_r;

  // datapath
  logic [CW-1:0]       old_val;
  logic [CW-1:0]       new_val;
  logic [VAL_W+CW-1:0] val_ext;
  cbf_upd_t            upd;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [CW-1:0]       wr_data;

  assign s1_fire     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !clearing && (!s1_vld_r || s1_fire);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // reset sweep
  cbf_clear #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_clear (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .clr_addr (clr_addr)
  );

  // write port: sweep during clear, else write-back of stage 1
  assign wr_en   = clearing || (s1_fire && upd.wr);
  assign wr_addr = clearing ? clr_addr : s1_idx_r[AW-1:0];
  assign wr_data = clearing ? '0 : new_val;

  cbf_counter_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_ch.index[AW-1:0]),
    .rd_data (old_val),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_ch.kind;
      s1_idx_r  <= in_ch.index;
      s1_last_r <= in_ch.last;
    end
  end

  assign s1_in_range = 32'(s1_idx_r) < 32'(TABLE_SIZE);

  cbf_update #(
    .CW (CW)
  ) u_update (
    .kind     (s1_kind_r),
    .in_range (s1_in_range),
    .old_val  (old_val),
    .new_val  (new_val),
    .upd      (upd)
  );

  // occupancy and group flag
  always_comb begin
    occ_nxt = occ_r;
    if (upd.inc) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (upd.dec) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
    all_now = grp_r && upd.nonzero;
    grp_nxt = s1_last_r ? 1'b1 : all_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      grp_r <= 1'b1;
    end else if (s1_fire) begin
      occ_r <= occ_nxt;
      grp_r <= grp_nxt;
    end
  end

  // result register
  assign val_ext = {{VAL_W{1'b0}}, new_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_slot_r  <= s1_idx_r;
      out_value_r <= val_ext[VAL_W-1:0];
      out_all_r   <= all_now;
      out_end_r   <= s1_last_r;
      out_cnt_r   <= occ_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.value         = out_value_r;
  assign out_ch.all_present   = out_all_r;
  assign out_ch.group_end     = out_end_r;
  assign out_ch.nonzero_count = out_cnt_r;

`ifndef ASSERT_OFF
  // no item enters while the RAM is being zeroed
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ch.ready && !s1_vld_r)
    else $error("item taken during clear sweep");

  // a stalled stage 1 item keeps its place and index
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_fire) |=> (s1_vld_r && $stable(s1_idx_r) && $stable(s1_kind_r)))
    else $error("stage 1 item lost while stalled");

  // group flag rearms after the last item of a group
  a_grp_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> grp_r)
    else $error("group flag not rearmed");

  // occupancy moves by at most one per item, only when a result is produced
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(occ_r))
    else $error("occupancy changed without an item");
`endif

endmodule : counting_bloom_filter_core
`default_nettype wire
